/* hdl/dmms_pkg.sv */
// dmms_pkg: shared types and constants for the dictionary segmenter.
// No dependencies.
`timescale 1ns / 1ps
package dmms_pkg;

  localparam int TermSlots  = 4096;
  localparam int TslotW     = 12;
  localparam int IndexSlots = 1024;
  localparam int IdxW       = 10;
  localparam int TermBytes  = 64;
  localparam int TbW        = 6;
  localparam int MaxWindow  = 64;
  localparam int BufW       = 6;

  typedef enum logic [1:0] {
    OP_TBYTE = 2'd0,
    OP_TLEN  = 2'd1,
    OP_INDEX = 2'd2,
    OP_TEXT  = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_WINDOW = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_e;

  typedef enum logic [0:0] {
    KIND_TOKEN = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RK0, S_RK1, S_RK2, S_BS_ISSUE, S_BS_CMP, S_F_RD, S_F_ST,
    S_SC_ISSUE, S_SC_LEN, S_SC_BYTE, S_SC_BCHK, S_EMIT, S_NOMATCH, S_DA_RD,
    S_DA_CHK, S_MARK
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] token_offset;
    logic [6:0]  token_length;
    logic        end_flag;
  } res_t;

endpackage

/* hdl/dmms_if.sv */
// dmms_if: valid/ready channels for input items, results and configuration.
// Depends on nothing.
`timescale 1ns / 1ps
interface dmms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] slot;
  logic [5:0]  byte_pos;
  logic [15:0] value;
  logic [11:0] range_end;
  logic        last;
  modport source (output valid, op, slot, byte_pos, value, range_end, last, input ready);
  modport sink (input valid, op, slot, byte_pos, value, range_end, last, output ready);
endinterface

interface dmms_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] token_offset;
  logic [6:0]  token_length;
  logic        end_flag;
  modport source (output valid, kind, token_offset, token_length, end_flag, input ready);
  modport sink (input valid, kind, token_offset, token_length, end_flag, output ready);
endinterface

interface dmms_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/dmms_ram.sv */
// dmms_ram: generic one-write one-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dmms_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hdl/dmms_outreg.sv */
// dmms_outreg: output register decoupling the engine from the result sink.
// Depends on dmms_pkg, dmms_if.
`timescale 1ns / 1ps
module dmms_outreg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  dmms_pkg::res_t push_data_i,
  dmms_out_if.source     out_s
);
  logic           valid_q;
  dmms_pkg::res_t data_q;

  assign push_ready_o = !valid_q || out_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_ready_o) begin
      valid_q <= push_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ready_o && push_valid_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_s.valid        = valid_q;
  assign out_s.kind         = data_q.kind;
  assign out_s.token_offset = data_q.token_offset;
  assign out_s.token_length = data_q.token_length;
  assign out_s.end_flag     = data_q.end_flag;
endmodule

/* hdl/dmms_ctrl.sv */
// dmms_ctrl: term/index/window memories and the search and scan sequencer.
// Depends on dmms_pkg, dmms_if, dmms_ram.
`timescale 1ns / 1ps
module dmms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  dmms_in_if.sink         in_s,
  dmms_cfg_if.sink        cfg_s,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output dmms_pkg::res_t  push_data_o
);
  dmms_pkg::state_e state_q, state_d;

  logic [6:0]  win_q;
  logic [10:0] cnt_q;
  logic [5:0]  hd_q;
  logic [6:0]  fill_q;
  logic [15:0] off_q;
  logic        last_q;
  logic [15:0] key_q;
  logic signed [11:0] lo_q, hi_q;
  logic [9:0]  mid_q;
  logic [12:0] start_q;
  logic [11:0] t_q;
  logic [6:0]  len_q;
  logic [5:0]  i_q;

  logic [6:0]  win, wl;
  logic [10:0] cnt_eff;
  logic [10:0] mid_sum;
  logic [9:0]  mid;
  logic        acc, text_acc, in_ascii;
  logic        adv_en;
  logic [6:0]  adv_n;
  logic        fill_dec;
  logic [16:0] off_sum;

  logic        tb_we, len_we, idx_we, buf_we;
  logic [17:0] tb_raddr;
  logic [7:0]  tb_rdata;
  logic [11:0] len_raddr;
  logic [6:0]  len_rdata;
  logic [9:0]  idx_raddr;
  logic [27:0] idx_rdata;
  logic [5:0]  buf_raddr;
  logic [7:0]  buf_rdata;
  logic [15:0] idx_key;
  logic        len_ok, len_short, byte_eq, byte_last, t_end, rd_ascii;

  assign win     = (win_q < 7'd2) ? 7'd2 :
                   (win_q > 7'(dmms_pkg::MaxWindow)) ? 7'(dmms_pkg::MaxWindow) : win_q;
  assign wl      = (fill_q < win) ? fill_q : win;
  assign cnt_eff = (cnt_q > 11'(dmms_pkg::IndexSlots)) ? 11'(dmms_pkg::IndexSlots) : cnt_q;
  assign mid_sum = {1'b0, lo_q[9:0]} + {1'b0, hi_q[9:0]};
  assign mid     = mid_sum[10:1];

  assign acc      = in_s.valid && in_s.ready;
  assign text_acc = acc && (in_s.op == dmms_pkg::OP_TEXT);
  assign in_ascii = (in_s.value[7:0] != 8'd0) && !in_s.value[7];

  assign tb_we  = acc && (in_s.op == dmms_pkg::OP_TBYTE);
  assign len_we = acc && (in_s.op == dmms_pkg::OP_TLEN);
  assign idx_we = acc && (in_s.op == dmms_pkg::OP_INDEX) &&
                  (in_s.slot < 12'(dmms_pkg::IndexSlots));
  assign buf_we = text_acc && !((fill_q == 7'd0) && in_ascii) &&
                  (fill_q < 7'(dmms_pkg::MaxWindow));

  assign idx_key   = idx_rdata[27:12];
  assign len_short = len_rdata < 7'd2;
  assign len_ok    = (len_rdata <= wl) && (len_rdata <= 7'(dmms_pkg::TermBytes));
  assign byte_eq   = tb_rdata == buf_rdata;
  assign byte_last = ({1'b0, i_q} + 7'd1) == len_q;
  assign t_end     = {1'b0, t_q} == start_q;
  assign rd_ascii  = (buf_rdata != 8'd0) && !buf_rdata[7];

  dmms_ram #(.AW(dmms_pkg::TslotW + dmms_pkg::TbW), .DW(8)) u_tb (
    .clk_i, .we_i(tb_we), .waddr_i({in_s.slot, in_s.byte_pos}),
    .wdata_i(in_s.value[7:0]), .raddr_i(tb_raddr), .rdata_o(tb_rdata));
  dmms_ram #(.AW(dmms_pkg::TslotW), .DW(7)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(in_s.slot),
    .wdata_i(in_s.value[6:0]), .raddr_i(len_raddr), .rdata_o(len_rdata));
  dmms_ram #(.AW(dmms_pkg::IdxW), .DW(28)) u_idx (
    .clk_i, .we_i(idx_we), .waddr_i(in_s.slot[9:0]),
    .wdata_i({in_s.value, in_s.range_end}), .raddr_i(idx_raddr), .rdata_o(idx_rdata));
  dmms_ram #(.AW(dmms_pkg::BufW), .DW(8)) u_buf (
    .clk_i, .we_i(buf_we), .waddr_i(hd_q + fill_q[5:0]),
    .wdata_i(in_s.value[7:0]), .raddr_i(buf_raddr), .rdata_o(buf_rdata));

  always_comb begin
    state_d = state_q;
    case (state_q)
      dmms_pkg::S_IDLE:     if (text_acc) state_d = dmms_pkg::S_CHECK;
      dmms_pkg::S_CHECK: begin
        if (last_q) state_d = (fill_q != 7'd0) ? dmms_pkg::S_RK0 : dmms_pkg::S_MARK;
        else if (fill_q != 7'd0 && fill_q >= win) state_d = dmms_pkg::S_RK0;
        else state_d = dmms_pkg::S_IDLE;
      end
      dmms_pkg::S_RK0:      state_d = dmms_pkg::S_RK1;
      dmms_pkg::S_RK1:      state_d = dmms_pkg::S_RK2;
      dmms_pkg::S_RK2:      state_d = dmms_pkg::S_BS_ISSUE;
      dmms_pkg::S_BS_ISSUE: state_d = (lo_q > hi_q) ? dmms_pkg::S_NOMATCH : dmms_pkg::S_BS_CMP;
      dmms_pkg::S_BS_CMP:   state_d = (idx_key == key_q) ? dmms_pkg::S_F_RD :
                                      dmms_pkg::S_BS_ISSUE;
      dmms_pkg::S_F_RD:     state_d = (mid_q == 10'd0) ? dmms_pkg::S_SC_ISSUE : dmms_pkg::S_F_ST;
      dmms_pkg::S_F_ST:     state_d = dmms_pkg::S_SC_ISSUE;
      dmms_pkg::S_SC_ISSUE: state_d = ({1'b0, t_q} < start_q) ? dmms_pkg::S_NOMATCH :
                                      dmms_pkg::S_SC_LEN;
      dmms_pkg::S_SC_LEN: begin
        if (len_short) state_d = dmms_pkg::S_NOMATCH;
        else if (len_ok) state_d = dmms_pkg::S_SC_BYTE;
        else state_d = t_end ? dmms_pkg::S_NOMATCH : dmms_pkg::S_SC_ISSUE;
      end
      dmms_pkg::S_SC_BYTE:  state_d = dmms_pkg::S_SC_BCHK;
      dmms_pkg::S_SC_BCHK: begin
        if (!byte_eq) state_d = t_end ? dmms_pkg::S_NOMATCH : dmms_pkg::S_SC_ISSUE;
        else state_d = byte_last ? dmms_pkg::S_EMIT : dmms_pkg::S_SC_BYTE;
      end
      dmms_pkg::S_EMIT:     if (push_ready_i) state_d = dmms_pkg::S_DA_RD;
      dmms_pkg::S_NOMATCH:  state_d = dmms_pkg::S_DA_RD;
      dmms_pkg::S_DA_RD:    state_d = (fill_q == 7'd0) ? dmms_pkg::S_CHECK : dmms_pkg::S_DA_CHK;
      dmms_pkg::S_DA_CHK:   state_d = rd_ascii ? dmms_pkg::S_DA_RD : dmms_pkg::S_CHECK;
      dmms_pkg::S_MARK:     if (push_ready_i) state_d = dmms_pkg::S_IDLE;
      default:              state_d = dmms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_s.ready   = state_q == dmms_pkg::S_IDLE;
    cfg_s.ready  = 1'b1;
    push_valid_o = (state_q == dmms_pkg::S_EMIT) || (state_q == dmms_pkg::S_MARK);
    push_data_o.kind         = (state_q == dmms_pkg::S_MARK) ? dmms_pkg::KIND_END :
                                                               dmms_pkg::KIND_TOKEN;
    push_data_o.token_offset = off_q;
    push_data_o.token_length = (state_q == dmms_pkg::S_MARK) ? 7'd0 : len_q;
    push_data_o.end_flag     = state_q == dmms_pkg::S_MARK;
    tb_raddr  = {t_q, i_q};
    len_raddr = t_q;
    idx_raddr = (state_q == dmms_pkg::S_F_RD) ? (mid_q - 10'd1) : mid;
    case (state_q)
      dmms_pkg::S_RK1:     buf_raddr = hd_q + 6'd1;
      dmms_pkg::S_SC_BYTE: buf_raddr = hd_q + i_q;
      default:             buf_raddr = hd_q;
    endcase
    adv_en   = 1'b0;
    adv_n    = 7'd0;
    fill_dec = 1'b1;
    case (state_q)
      dmms_pkg::S_IDLE: begin
        adv_en   = text_acc && (fill_q == 7'd0) && in_ascii;
        adv_n    = 7'd1;
        fill_dec = 1'b0;
      end
      dmms_pkg::S_EMIT: begin
        adv_en = push_ready_i;
        adv_n  = len_q;
      end
      dmms_pkg::S_NOMATCH: begin
        adv_en = 1'b1;
        adv_n  = (fill_q >= 7'd2) ? 7'd2 : fill_q;
      end
      dmms_pkg::S_DA_CHK: begin
        adv_en = rd_ascii;
        adv_n  = 7'd1;
      end
      default: adv_en = 1'b0;
    endcase
    off_sum = {1'b0, off_q} + {10'd0, adv_n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmms_pkg::S_IDLE;
      win_q   <= 7'd8;
      cnt_q   <= 11'd0;
      hd_q    <= 6'd0;
      fill_q  <= 7'd0;
      off_q   <= 16'd0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_s.valid && cfg_s.ready) begin
        case (cfg_s.index)
          dmms_pkg::CFG_WINDOW: win_q <= cfg_s.data[6:0];
          dmms_pkg::CFG_COUNT:  cnt_q <= cfg_s.data;
          default:              win_q <= win_q;
        endcase
      end
      if (text_acc) last_q <= in_s.last;
      if (buf_we) fill_q <= fill_q + 7'd1;
      if (adv_en) begin
        off_q <= off_sum[16] ? 16'hFFFF : off_sum[15:0];
        if (fill_dec) begin
          hd_q   <= hd_q + adv_n[5:0];
          fill_q <= fill_q - adv_n;
        end
      end
      if (state_q == dmms_pkg::S_MARK && push_ready_i) begin
        fill_q <= 7'd0;
        off_q  <= 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dmms_pkg::S_RK1: key_q[15:8] <= buf_rdata;
      dmms_pkg::S_RK2: begin
        key_q[7:0] <= (fill_q >= 7'd2) ? buf_rdata : 8'd0;
        lo_q <= 12'sd0;
        hi_q <= $signed({1'b0, cnt_eff}) - 12'sd1;
      end
      dmms_pkg::S_BS_ISSUE: mid_q <= mid;
      dmms_pkg::S_BS_CMP: begin
        t_q   <= idx_rdata[11:0];
        if (key_q > idx_key) lo_q <= $signed({2'b0, mid_q}) + 12'sd1;
        else hi_q <= $signed({2'b0, mid_q}) - 12'sd1;
      end
      dmms_pkg::S_F_RD:  start_q <= 13'd0;
      dmms_pkg::S_F_ST:  start_q <= {1'b0, idx_rdata[11:0]} + 13'd1;
      dmms_pkg::S_SC_LEN: begin
        len_q <= len_rdata;
        i_q   <= 6'd0;
        if (!len_ok) t_q <= t_q - 12'd1;
      end
      dmms_pkg::S_SC_BCHK: begin
        if (!byte_eq) t_q <= t_q - 12'd1;
        else i_q <= i_q + 6'd1;
      end
      default: i_q <= i_q;
    endcase
  end
endmodule

/* hdl/dictionary_max_match_segmenter.sv */
// Dictionary maximum-match segmenter, double-byte text, load and text ops.
// Items are accepted only while idle; a text byte is accepted, then checked. Each decision
// builds the key, binary-searches the index (up to 11 probes), finds the range start, reads
// term lengths and compares bytes, emits or skips, drops ASCII head bytes, ends the head check
// and rechecks; the end marker is pushed last. Output stalls hold the emit and marker states.
// One item at a time via one output register; reset clears control state, memories undefined.
`timescale 1ns / 1ps
module dictionary_max_match_segmenter (
  input  logic     clk_i,
  input  logic     rst_ni,
  dmms_in_if.sink  in_s,
  dmms_cfg_if.sink cfg_s,
  dmms_out_if.source out_s
);
  logic           push_valid, push_ready;
  dmms_pkg::res_t push_data;

  dmms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_s, .cfg_s,
    .push_valid_o(push_valid), .push_ready_i(push_ready), .push_data_o(push_data));

  dmms_outreg u_outreg (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_data_i(push_data),
    .out_s);
endmodule
